FILE: hw/rtl/bed_pkg.sv
// bed_pkg: shared constants for the button event detector
// holds stamp width, register indexes, event codes and register reset values
// no dependencies
package bed_pkg;

   // tick counter width, low 32 bits appear on the stamp port
   localparam int unsigned STAMP_BITS = 32;
   localparam int unsigned OUT_STAMP_BITS = 32;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOUBLE_CLICK = 2'd2;

   // register reset values
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd2;
   localparam logic [15:0] LONG_PRESS_RESET   = 16'd100;
   localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd30;

   // event codes
   typedef logic [1:0] event_kind_type;
   localparam event_kind_type EV_PRESSED      = 2'd0;
   localparam event_kind_type EV_RELEASED     = 2'd1;
   localparam event_kind_type EV_LONG_PRESS   = 2'd2;
   localparam event_kind_type EV_DOUBLE_CLICK = 2'd3;

   // click count codes
   localparam logic [1:0] CLICKS_NONE = 2'd0;
   localparam logic [1:0] CLICKS_TWO  = 2'd2;
   localparam logic [1:0] CLICKS_MAX  = 2'd3;

   typedef logic [STAMP_BITS-1:0] stamp_type;

endpackage

FILE: hw/rtl/button_event_detector.sv
// button_event_detector: debounce, press/release, long press and double click
// events from a raw active-low key level sampled once per scan tick
// depends on bed_pkg
//
// usage
//  - req channel: one word per scan tick carrying the raw key level
//    (1 released, 0 pressed); taken when req_valid is high and req_stall low
//  - rsp channel: at most one event word per tick, kind plus tick stamp;
//    taken when rsp_valid is high and rsp_stall low
//  - csr port: write debounce (0), long press (1) and double click (2)
//    tick counts while the block is idle; a value of zero acts as one
//  - order: a tick enters an input register and is evaluated there once the
//    event register is free; its event is then registered and shown on rsp
//  - throughput: one tick per clock cycle while no event waits under rsp_stall,
//    set by the single evaluation stage between the input and event registers
//  - a waiting event does not block the next tick from entering the input
//    register; once both registers hold work and rsp_stall is high,
//    req_stall rises until the event is taken
//  - reset clears the tick counter, the debounce and click state and loads
//    the register reset values; no event is pending after reset
module button_event_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_pin_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_event_kind,
   output logic [bed_pkg::OUT_STAMP_BITS-1:0]    rsp_stamp,
   input  logic                                  csr_write,
   input  logic [bed_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bed_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   // configuration registers
   logic [7:0]  debounce_ff;
   logic [15:0] long_press_ff;
   logic [15:0] double_click_ff;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_pin_ff, in_pin_in;

   // detector state
   bed_pkg::stamp_type tick_ff, tick_in;
   logic               accepted_level_ff, accepted_level_in;
   logic [7:0]         stable_ff, stable_in;
   logic               held_down_ff, held_down_in;
   bed_pkg::stamp_type press_stamp_ff, press_stamp_in;
   bed_pkg::stamp_type release_stamp_ff, release_stamp_in;
   logic [1:0]         clicks_ff, clicks_in;
   logic               long_sent_ff, long_sent_in;

   // event register
   logic                          out_valid_ff, out_valid_in;
   bed_pkg::event_kind_type       out_kind_ff, out_kind_in;
   logic [bed_pkg::OUT_STAMP_BITS-1:0] out_stamp_ff, out_stamp_in;

   // evaluation signals
   logic               advance;
   logic               level_differs;
   logic [7:0]         stable_inc;
   logic [7:0]         debounce_min;
   logic [15:0]        long_min;
   logic [15:0]        double_min;
   logic               level_taken;
   bed_pkg::stamp_type since_press;
   bed_pkg::stamp_type since_release;
   logic               long_fire;
   logic               window_close;
   logic               fire;
   bed_pkg::event_kind_type fire_kind;

   // handshake: the input stage moves on when the event register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_stamp      = out_stamp_ff;

   // zero settings act as one
   assign debounce_min = (debounce_ff == 8'd0) ? 8'd1 : debounce_ff;
   assign long_min     = (long_press_ff == 16'd0) ? 16'd1 : long_press_ff;
   assign double_min   = (double_click_ff == 16'd0) ? 16'd1 : double_click_ff;

   // debounce
   assign level_differs = in_pin_ff != accepted_level_ff;
   assign stable_inc    = (stable_ff == 8'hFF) ? stable_ff : stable_ff + 8'd1;
   assign level_taken   = level_differs && (stable_inc >= debounce_min);

   // elapsed times wrap with the tick counter
   assign since_press   = tick_ff - press_stamp_ff;
   assign since_release = tick_ff - release_stamp_ff;

   // long press once per hold, then the click window check
   assign long_fire = !level_taken && held_down_ff && !long_sent_ff &&
                      (since_press >= bed_pkg::stamp_type'(long_min));
   assign window_close = !level_taken && !long_fire && !held_down_ff &&
                         (clicks_ff != bed_pkg::CLICKS_NONE) &&
                         (since_release >= bed_pkg::stamp_type'(double_min));

   // event selection
   always_comb begin
      fire      = 1'b0;
      fire_kind = bed_pkg::EV_PRESSED;
      priority if (level_taken) begin
         fire      = 1'b1;
         fire_kind = in_pin_ff ? bed_pkg::EV_RELEASED : bed_pkg::EV_PRESSED;
      end else if (long_fire) begin
         fire      = 1'b1;
         fire_kind = bed_pkg::EV_LONG_PRESS;
      end else if (window_close && (clicks_ff == bed_pkg::CLICKS_TWO)) begin
         fire      = 1'b1;
         fire_kind = bed_pkg::EV_DOUBLE_CLICK;
      end else begin
         fire      = 1'b0;
         fire_kind = bed_pkg::EV_PRESSED;
      end
   end

   // next state for the detector
   always_comb begin
      tick_in           = tick_ff;
      accepted_level_in = accepted_level_ff;
      stable_in         = stable_ff;
      held_down_in      = held_down_ff;
      press_stamp_in    = press_stamp_ff;
      release_stamp_in  = release_stamp_ff;
      clicks_in         = clicks_ff;
      long_sent_in      = long_sent_ff;
      if (advance) begin
         tick_in   = tick_ff + bed_pkg::stamp_type'(1);
         stable_in = level_differs ? (level_taken ? 8'd0 : stable_inc) : 8'd0;
         if (level_taken) begin
            accepted_level_in = in_pin_ff;
            held_down_in      = !in_pin_ff;
            if (!in_pin_ff) begin
               press_stamp_in = tick_ff;
               if (clicks_ff != bed_pkg::CLICKS_MAX) begin
                  clicks_in = clicks_ff + 2'd1;
               end
            end else begin
               release_stamp_in = tick_ff;
               long_sent_in     = 1'b0;
            end
         end
         if (long_fire) begin
            long_sent_in = 1'b1;
         end
         if (window_close) begin
            clicks_in = bed_pkg::CLICKS_NONE;
         end
      end
   end

   // input register next state
   always_comb begin
      in_valid_in = in_valid_ff;
      in_pin_in   = in_pin_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_pin_in   = req_pin_level;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // event register next state
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_stamp_in = out_stamp_ff;
      if (advance) begin
         out_valid_in = fire;
         out_kind_in  = fire_kind;
         out_stamp_in = bed_pkg::OUT_STAMP_BITS'(tick_ff);
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= bed_pkg::DEBOUNCE_RESET;
         long_press_ff   <= bed_pkg::LONG_PRESS_RESET;
         double_click_ff <= bed_pkg::DOUBLE_CLICK_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            bed_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_wdata[7:0];
            bed_pkg::CSR_LONG_PRESS:   long_press_ff   <= csr_wdata;
            bed_pkg::CSR_DOUBLE_CLICK: double_click_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         tick_ff           <= '0;
         accepted_level_ff <= 1'b1;
         stable_ff         <= 8'd0;
         held_down_ff      <= 1'b0;
         press_stamp_ff    <= '0;
         release_stamp_ff  <= '0;
         clicks_ff         <= bed_pkg::CLICKS_NONE;
         long_sent_ff      <= 1'b0;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         tick_ff           <= tick_in;
         accepted_level_ff <= accepted_level_in;
         stable_ff         <= stable_in;
         held_down_ff      <= held_down_in;
         press_stamp_ff    <= press_stamp_in;
         release_stamp_ff  <= release_stamp_in;
         clicks_ff         <= clicks_in;
         long_sent_ff      <= long_sent_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_pin_ff    <= in_pin_in;
      out_kind_ff  <= out_kind_in;
      out_stamp_ff <= out_stamp_in;
   end

`ifndef SYNTHESIS
   // held state always mirrors the accepted level
   a_held_matches_level: assert property (@(posedge clock) disable iff (reset)
      held_down_ff == !accepted_level_ff)
      else $error("held_down out of step with accepted level");

   // long press flag only set during a hold
   a_long_sent_held: assert property (@(posedge clock) disable iff (reset)
      long_sent_ff |-> held_down_ff)
      else $error("long press flag set while released");

   // an evaluated tick with an event lands in the event register
   a_event_registered: assert property (@(posedge clock) disable iff (reset)
      (advance && fire) |=> rsp_valid)
      else $error("event lost between stages");
`endif

endmodule

FILE: sim/tb_button_event_detector.sv
// tb_button_event_detector: self-checking bench for the button event detector
// drives scan ticks and register writes, predicts every event and checks it on rsp
// depends on bed_pkg and button_event_detector
module tb_button_event_detector;
   timeunit 1ns;
   timeprecision 1ps;

   import bed_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_WAIT = 16;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      event_kind_type              kind;
      logic [OUT_STAMP_BITS-1:0]   stamp;
   } key_event_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_pin_level = 1'b1;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_event_kind;
   logic [OUT_STAMP_BITS-1:0]   rsp_stamp;
   logic                        csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = CSR_DEBOUNCE;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   // predicted detector state and register copies
   logic [7:0]   cfg_debounce = DEBOUNCE_RESET;
   logic [15:0]  cfg_long = LONG_PRESS_RESET;
   logic [15:0]  cfg_double = DOUBLE_CLICK_RESET;
   stamp_type    scan_ticks = '0;
   logic         debounced_level = 1'b1;
   logic [7:0]   settle_count = '0;
   logic         key_down = 1'b0;
   stamp_type    down_stamp = '0;
   stamp_type    up_stamp = '0;
   logic [1:0]   press_tally = CLICKS_NONE;
   logic         long_reported = 1'b0;

   key_event_type pending_events[$];
   int           mismatch_count = 0;
   int           ticks_sent = 0;
   int           idle_cycles = 0;
   int           rsp_wait_left = 0;
   bit           gaps_on = 1'b1;

   button_event_detector DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pin_level  (req_pin_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_stamp      (rsp_stamp),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] nonzero_or_one(input logic [15:0] value);
      return (value == 16'd0) ? 16'd1 : value;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // one scan tick through the predicted detector, queues the event it raises
   function automatic void detect_key_event(input logic level);
      stamp_type   now;
      logic        taken;
      logic        fired;
      key_event_type ev;
      now = scan_ticks;
      taken = 1'b0;
      fired = 1'b0;
      ev = '0;

      // debounce: a changed level must persist before it is taken
      if (level != debounced_level) begin
         if (settle_count != 8'd255) begin
            settle_count++;
         end
         if ({8'd0, settle_count} >= nonzero_or_one({8'd0, cfg_debounce})) begin
            debounced_level = level;
            settle_count = '0;
            taken = 1'b1;
         end
      end else begin
         settle_count = '0;
      end

      // edge of the debounced level
      if (taken) begin
         fired = 1'b1;
         if (!debounced_level) begin
            key_down = 1'b1;
            down_stamp = now;
            if (press_tally != CLICKS_MAX) begin
               press_tally++;
            end
            ev.kind = EV_PRESSED;
         end else begin
            key_down = 1'b0;
            up_stamp = now;
            long_reported = 1'b0;
            ev.kind = EV_RELEASED;
         end
      end

      // one long press per hold
      if (!fired && key_down && !long_reported &&
          (now - down_stamp) >= nonzero_or_one(cfg_long)) begin
         long_reported = 1'b1;
         fired = 1'b1;
         ev.kind = EV_LONG_PRESS;
      end

      // click window closes after the quiet period, only a pair counts
      if (!fired && !key_down && press_tally != CLICKS_NONE &&
          (now - up_stamp) >= nonzero_or_one(cfg_double)) begin
         if (press_tally == CLICKS_TWO) begin
            fired = 1'b1;
            ev.kind = EV_DOUBLE_CLICK;
         end
         press_tally = CLICKS_NONE;
      end

      scan_ticks++;
      if (fired) begin
         ev.stamp = now[OUT_STAMP_BITS-1:0];
         pending_events.push_back(ev);
      end
   endfunction

   // result side: a stall is drawn each time a word is taken and held against the next word until its wait runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait_left = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
         rsp_stall <= (rsp_wait_left != 0);
      end else if (rsp_valid && rsp_wait_left > 0) begin
         rsp_wait_left--;
         rsp_stall <= (rsp_wait_left != 0);
      end
   end

   // compare each taken event word with the oldest prediction
   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            note_mismatch($sformatf("unexpected event: kind %0d stamp %0d",
                                    rsp_event_kind, rsp_stamp));
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind || rsp_stamp !== want.stamp) begin
               note_mismatch($sformatf("event mismatch: expected kind %0d stamp %0d, got kind %0d stamp %0d",
                                       want.kind, want.stamp, rsp_event_kind, rsp_stamp));
            end
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAIL button_event_detector");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one scan tick word, with an optional gap in front
   task automatic send_tick(input logic level);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin_level <= level;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
      detect_key_event(level);
   endtask

   task automatic hold_level(input logic level, input int count, input bit noisy);
      for (int i = 0; i < count; i++) begin
         send_tick((noisy && $urandom_range(0, 19) == 0) ? ~level : level);
      end
   endtask

   // stop sending and let every event and the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers plus a stray index, only while idle
   task automatic load_registers(input logic [15:0] debounce_val, input logic [15:0] long_val,
                                 input logic [15:0] double_val);
      logic [15:0] stray;
      stray = 16'($urandom_range(0, 16'hFFFF));
      settle();
      csr_write <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= debounce_val;
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= long_val;
      @(posedge clock);
      csr_index <= CSR_DOUBLE_CLICK;
      csr_wdata <= double_val;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= stray;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_debounce = debounce_val[7:0];
      cfg_long = long_val;
      cfg_double = double_val;
   endtask

   // reset register values: a glitch shorter than debounce, then press and release
   task automatic test_reset_defaults();
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      hold_level(1'b0, 2, 1'b0);
      hold_level(1'b1, 2, 1'b0);
   endtask

   // hold past the long press threshold, one long press only
   task automatic test_long_press();
      hold_level(1'b0, 7, 1'b0);
      hold_level(1'b1, 1, 1'b0);
   endtask

   // single click expiry, double click, and a click count that saturates
   task automatic test_click_counts();
      hold_level(1'b1, 4, 1'b0);
      hold_level(1'b0, 1, 1'b0);
      hold_level(1'b1, 4, 1'b0);
      for (int i = 0; i < 2; i++) begin
         send_tick(1'b0);
         send_tick(1'b1);
      end
      hold_level(1'b1, 3, 1'b0);
      for (int i = 0; i < 4; i++) begin
         send_tick(1'b0);
         send_tick(1'b1);
      end
      hold_level(1'b1, 3, 1'b0);
   endtask

   // random presses, releases, bounces and noise scaled to the register setting
   task automatic test_random_gestures(input logic [15:0] debounce_val,
                                       input logic [15:0] long_val,
                                       input logic [15:0] double_val,
                                       input int quota, input bit with_gaps);
      int db;
      int long_cap;
      int double_cap;
      int stop_at;
      bit noisy;
      load_registers(debounce_val, long_val, double_val);
      gaps_on = with_gaps;
      db = nonzero_or_one({8'd0, cfg_debounce});
      long_cap = (nonzero_or_one(cfg_long) > 40) ? 40 : nonzero_or_one(cfg_long);
      double_cap = (nonzero_or_one(cfg_double) > 40) ? 40 : nonzero_or_one(cfg_double);
      stop_at = ticks_sent + quota;
      while (ticks_sent < stop_at) begin
         noisy = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: begin
               hold_level(1'b1, $urandom_range(1, 8), 1'b1);
               hold_level(1'b0, $urandom_range(1, 8), 1'b1);
            end
            1: begin
               hold_level(1'b0, $urandom_range(1, db), 1'b0);
               hold_level(1'b1, $urandom_range(1, db), 1'b0);
            end
            default: begin
               hold_level(1'b0, $urandom_range(db, db + long_cap + 4), noisy);
               hold_level(1'b1, $urandom_range(db, db + double_cap + 4), noisy);
            end
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      // debounce written as zero, upper data bits dropped
      load_registers(16'h5A00, 16'd4, 16'd3);
      test_long_press();
      test_click_counts();

      test_random_gestures(16'd1, 16'd5, 16'd4, 120, 1'b1);
      test_random_gestures(16'd3, 16'd25, 16'd12, 120, 1'b0);
      test_random_gestures(16'd0, 16'd0, 16'd0, 80, 1'b1);
      test_random_gestures(16'd2, 16'd12, 16'hFFFF, 80, 1'b0);
      test_random_gestures(16'd255, 16'hFFFF, 16'd1, 1, 1'b1);
      test_random_gestures(16'd1, 16'd3, 16'd2, 100, 1'b1);

      settle();
      if (mismatch_count == 0) begin
         $display("PASS button_event_detector");
      end else begin
         $display("FAIL button_event_detector");
      end
      $finish;
   end

endmodule

FILE: button_event_detector.f
hw/rtl/bed_pkg.sv
hw/rtl/button_event_detector.sv
sim/tb_button_event_detector.sv
